[rtl/core/nrid_pkg.sv]
package nrid_pkg;

  localparam int MAX_WIDTH     = 128;
  localparam int FRACTION_BITS = 16;
  localparam int PIX_W         = 8;
  localparam int COL_W         = $clog2(MAX_WIDTH);
  localparam int ROW_W         = 12;
  localparam int HEIGHT_LIMIT  = 4096;
  localparam int QUO_W         = PIX_W + 1 + FRACTION_BITS;
  localparam int SUM_W         = 48;
  localparam int NBR_N         = 4;
  localparam int STORE_AW      = COL_W + 1;
  localparam int ADDR_W        = 3;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  // neighbor slots
  localparam logic [1:0] NB_LEFT    = 2'd0;
  localparam logic [1:0] NB_UP      = 2'd1;
  localparam logic [1:0] NB_UPLEFT  = 2'd2;
  localparam logic [1:0] NB_UPRIGHT = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0]            a;
    logic [PIX_W-1:0]            b;
    logic [NBR_N-1:0][PIX_W-1:0] na;
    logic [NBR_N-1:0][PIX_W-1:0] nb;
    logic [NBR_N-1:0]            mask;
    logic                        last;
  } job_t;

endpackage

[rtl/core/nrid_div.sv]
module nrid_div
  import nrid_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [PIX_W-1:0] num,
  input  logic [PIX_W-1:0] den,
  output logic             busy,
  output logic [QUO_W-1:0] quo
);

  localparam int CNT_W = $clog2(QUO_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUO_W - 1);

  logic [QUO_W-1:0] dividend;
  logic [PIX_W:0]   divisor;
  logic [PIX_W+1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [PIX_W+1:0] trial;
  logic             take;

  assign trial = {rem[PIX_W:0], dividend[QUO_W-1]};
  assign take  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      if (cnt == LAST_STEP) begin
        busy <= 1'b0;
      end
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= {({1'b0, num} + 9'd1), {FRACTION_BITS{1'b0}}};
      divisor  <= {1'b0, den} + 9'd1;
      rem      <= '0;
      quo      <= '0;
    end else if (busy) begin
      dividend <= {dividend[QUO_W-2:0], 1'b0};
      rem      <= take ? (trial - {1'b0, divisor}) : trial;
      quo      <= {quo[QUO_W-2:0], take};
    end
  end

endmodule

[rtl/core/nrid_fifo.sv]
module nrid_fifo
  import nrid_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  job_t wdata,
  output logic wfull,
  input  logic rd,
  output job_t rdata,
  output logic rempty
);

  job_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign wfull  = count == 2'd2;
  assign rempty = count == 2'd0;
  assign rdata  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (wr && !wfull) wptr <= ~wptr;
      if (rd && !rempty) rptr <= ~rptr;
      count <= count + {1'b0, wr && !wfull} - {1'b0, rd && !rempty};
    end
  end

  always_ff @(posedge clk) begin
    if (wr && !wfull) slots[wptr] <= wdata;
  end

endmodule

[rtl/core/nrid_front.sv]
module nrid_front
  import nrid_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [PIX_W-1:0] pixel_a,
  input  logic [PIX_W-1:0] pixel_b,
  input  logic [7:0]       frame_width,
  input  logic [12:0]      frame_height,
  input  logic             restart,
  output logic             job_wr,
  output job_t             job,
  input  logic             job_full
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_READ = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t                     state;
  logic [2:0]                  step;
  logic [COL_W-1:0]            col;
  logic [ROW_W-1:0]            row;
  logic [COL_W-1:0]            x;
  logic                        par;
  logic [2*PIX_W-1:0]          store [2*MAX_WIDTH];
  logic [2*PIX_W-1:0]          rd_data;
  logic [STORE_AW-1:0]         rd_addr;
  logic [7:0]                  w;
  logic [12:0]                 h;
  logic [COL_W-1:0]            xc;
  logic [7:0]                  x_inc;
  logic                        row_end;
  logic                        frame_end;
  logic [1:0]                  slot;

  always_comb begin
    w = frame_width;
    if (frame_width == 8'd0) w = 8'd1;
    else if (frame_width > 8'(MAX_WIDTH)) w = 8'(MAX_WIDTH);
    h = frame_height;
    if (frame_height == 13'd0) h = 13'd1;
    else if (frame_height > 13'(HEIGHT_LIMIT)) h = 13'(HEIGHT_LIMIT);
  end

  always_comb begin
    xc = col;
    if ({1'b0, col} >= w) xc = COL_W'(w - 8'd1);
  end

  assign x_inc     = {1'b0, xc} + 8'd1;
  assign row_end   = x_inc >= w;
  assign frame_end = row_end && ({1'b0, row} + 13'd1 >= h);
  assign full      = state != F_IDLE;
  assign job_wr    = state == F_PUSH;
  assign slot      = 2'(step - 3'd1);

  always_comb begin
    unique case (step[1:0])
      NB_LEFT:    rd_addr = {par, x - 1'b1};
      NB_UP:      rd_addr = {~par, x};
      NB_UPLEFT:  rd_addr = {~par, x - 1'b1};
      NB_UPRIGHT: rd_addr = {~par, x + 1'b1};
      default:    rd_addr = {par, x};
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= store[rd_addr];
    if (state == F_READ && step == 3'd4) store[{par, x}] <= {job.a, job.b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      col   <= '0;
      row   <= '0;
      step  <= '0;
    end else if (restart) begin
      col <= '0;
      row <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (push) begin
            state <= F_READ;
            step  <= '0;
            if (row_end) begin
              col <= '0;
              row <= frame_end ? '0 : row + 1'b1;
            end else begin
              col <= x_inc[COL_W-1:0];
            end
          end
        end
        F_READ: begin
          step <= step + 3'd1;
          if (step == 3'd4) state <= F_PUSH;
        end
        F_PUSH: begin
          if (!job_full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && push) begin
      job.a    <= pixel_a;
      job.b    <= pixel_b;
      x        <= xc;
      par      <= row[0];
      job.last <= frame_end;
      job.mask[NB_LEFT]    <= xc != '0;
      job.mask[NB_UP]      <= row != '0;
      job.mask[NB_UPLEFT]  <= row != '0 && xc != '0;
      job.mask[NB_UPRIGHT] <= row != '0 && !row_end;
    end
    if (state == F_READ && step != 3'd0) begin
      job.na[slot] <= rd_data[2*PIX_W-1:PIX_W];
      job.nb[slot] <= rd_data[PIX_W-1:0];
    end
  end

endmodule

[rtl/core/nrid_back.sv]
module nrid_back
  import nrid_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             restart,
  input  logic             job_empty,
  input  job_t             job_in,
  output logic             job_rd,
  output logic             empty,
  input  logic             pop,
  output logic [SUM_W-1:0] distance
);

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_SEL  = 6'b000010,
    B_DIV  = 6'b000100,
    B_TERM = 6'b001000,
    B_ADD  = 6'b010000,
    B_END  = 6'b100000
  } bstate_t;

  bstate_t          state;
  job_t             job;
  logic [1:0]       j;
  logic [SUM_W-1:0] sum;
  logic             out_valid;
  logic             start;
  logic [3:0]       busy;
  logic [QUO_W-1:0] q0, q1, q2, q3;
  logic [QUO_W:0]   term;
  logic [QUO_W-1:0] d0, d1;
  logic [SUM_W:0]   sum_wide;

  assign start  = state == B_SEL && job.mask[j];
  assign job_rd = state == B_IDLE && !job_empty;
  assign empty  = !out_valid;

  nrid_div u_div0 (.clk, .rst, .start, .num(job.na[j]), .den(job.a),
                   .busy(busy[0]), .quo(q0));
  nrid_div u_div1 (.clk, .rst, .start, .num(job.nb[j]), .den(job.b),
                   .busy(busy[1]), .quo(q1));
  nrid_div u_div2 (.clk, .rst, .start, .num(job.a), .den(job.na[j]),
                   .busy(busy[2]), .quo(q2));
  nrid_div u_div3 (.clk, .rst, .start, .num(job.b), .den(job.nb[j]),
                   .busy(busy[3]), .quo(q3));

  assign d0       = q0 > q1 ? q0 - q1 : q1 - q0;
  assign d1       = q2 > q3 ? q2 - q3 : q3 - q2;
  assign sum_wide = {1'b0, sum} + (SUM_W+1)'(term);

  always_ff @(posedge clk) begin
    if (state == B_IDLE && !job_empty) job <= job_in;
    if (state == B_TERM) term <= {1'b0, d0} + {1'b0, d1};
    if (state == B_END && !out_valid) distance <= sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      j         <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) out_valid <= 1'b0;
      if (restart) sum <= '0;
      unique case (state)
        B_IDLE: begin
          j <= '0;
          if (!job_empty) state <= B_SEL;
        end
        B_SEL: begin
          if (job.mask[j]) state <= B_DIV;
          else if (j == 2'd3) state <= B_END;
          else j <= j + 2'd1;
        end
        B_DIV: begin
          if (busy == 4'd0) state <= B_TERM;
        end
        B_TERM: state <= B_ADD;
        B_ADD: begin
          sum <= sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
          if (j == 2'd3) begin
            state <= B_END;
          end else begin
            j     <= j + 2'd1;
            state <= B_SEL;
          end
        end
        B_END: begin
          if (!job.last) begin
            state <= B_IDLE;
          end else if (!out_valid) begin
            out_valid <= 1'b1;
            sum       <= '0;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/neighbor_ratio_image_distance.sv]
// Neighbor-ratio distance between two 8-bit images, one pixel pair per push in
// raster order. The front end takes a pixel, fetches its left and three upper
// neighbors from a two-row line store and queues the job, staying full until
// the job is queued. The back end runs four restoring dividers in parallel,
// one neighbor pair at a time, and reads the next job only when it is done
// with the last one; a two-entry FIFO sits between the two ends.
// One distance is produced at the last pixel of each frame. Writing
// frame_width or frame_height restarts the frame; write only while idle.
module neighbor_ratio_image_distance
  import nrid_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [PIX_W-1:0]       pixel_a,
  input  logic [PIX_W-1:0]       pixel_b,
  output logic                   empty,
  input  logic                   pop,
  output logic [SUM_W-1:0]       distance,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [7:0]  frame_width;
  logic [12:0] frame_height;
  logic        cfg_wr;
  logic        job_wr;
  logic        job_full;
  logic        job_rd;
  logic        job_empty;
  job_t        job_w;
  job_t        job_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_HEIGHT) ? {19'd0, frame_height} : {24'd0, frame_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 8'd128;
      frame_height <= 13'd128;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH) frame_width <= pwdata[7:0];
      else frame_height <= pwdata[12:0];
    end
  end

  nrid_front u_front (
    .clk, .rst, .push, .full, .pixel_a, .pixel_b,
    .frame_width, .frame_height, .restart(cfg_wr),
    .job_wr, .job(job_w), .job_full
  );

  nrid_fifo u_fifo (
    .clk, .rst, .wr(job_wr), .wdata(job_w), .wfull(job_full),
    .rd(job_rd), .rdata(job_r), .rempty(job_empty)
  );

  nrid_back u_back (
    .clk, .rst, .restart(cfg_wr), .job_empty, .job_in(job_r), .job_rd,
    .empty, .pop, .distance
  );

  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("reset left a result or a busy front end");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (push && !full && !cfg_wr) |=> full)
    else $error("front end took a transaction without its fetch sweep");

endmodule

[dv/tb.sv]
module tb;
  import nrid_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned SUM_MAX = 64'hFFFF_FFFF_FFFF;
  localparam logic [ADDR_W-1:0] ADDR_WIDTH  = ADDR_W'(4 * REG_WIDTH);
  localparam logic [ADDR_W-1:0] ADDR_HEIGHT = ADDR_W'(4 * REG_HEIGHT);

  typedef struct packed {
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
  } pix_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [PIX_W-1:0] pixel_a = '0;
  logic [PIX_W-1:0] pixel_b = '0;
  logic empty;
  logic pop = 1'b0;
  logic [SUM_W-1:0] distance;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  neighbor_ratio_image_distance i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pix_pair_t pixel_q[$];
  logic [SUM_W-1:0] distance_q[$];
  int errors = 0;
  int tx_idle = 7;
  int rx_idle = 52;

  // frame model
  logic [7:0] width_reg = 8'd128;
  logic [12:0] height_reg = 13'd128;
  logic [PIX_W-1:0] line_a[2*MAX_WIDTH];
  logic [PIX_W-1:0] line_b[2*MAX_WIDTH];
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  longint unsigned dist_sum = 0;

  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    if (height_reg == 0) return 1;
    if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return height_reg;
  endfunction

  function automatic longint unsigned weight(longint unsigned num, longint unsigned den);
    return ((num + 1) << FRACTION_BITS) / (den + 1);
  endfunction

  function automatic longint unsigned wdiff(longint unsigned x, longint unsigned y);
    return x > y ? x - y : y - x;
  endfunction

  function automatic void add_pair(int unsigned pa, int unsigned pb, int unsigned idx);
    longint unsigned cost;
    cost = wdiff(weight(line_a[idx], pa), weight(line_b[idx], pb))
         + wdiff(weight(pa, line_a[idx]), weight(pb, line_b[idx]));
    dist_sum = dist_sum + cost;
    if (dist_sum > SUM_MAX) dist_sum = SUM_MAX;
  endfunction

  function automatic void accumulate_pixel(logic [PIX_W-1:0] pa, logic [PIX_W-1:0] pb);
    int unsigned w, h, x, y, cur, prv;
    w = active_width();
    h = active_height();
    x = col_pos;
    y = row_pos;
    if (x >= w) x = w - 1;
    cur = (y & 1) * MAX_WIDTH;
    prv = ((y + 1) & 1) * MAX_WIDTH;
    if (x > 0) add_pair(pa, pb, cur + x - 1);
    if (y > 0) begin
      add_pair(pa, pb, prv + x);
      if (x > 0) add_pair(pa, pb, prv + x - 1);
      if (x + 1 < w) add_pair(pa, pb, prv + x + 1);
    end
    line_a[cur + x] = pa;
    line_b[cur + x] = pb;
    if (x + 1 < w) begin
      col_pos = x + 1;
    end else begin
      col_pos = 0;
      if (y + 1 < h) begin
        row_pos = y + 1;
      end else begin
        distance_q.push_back(dist_sum[SUM_W-1:0]);
        row_pos = 0;
        dist_sum = 0;
      end
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) accumulate_pixel(pixel_a, pixel_b);
      if (!push || !full) begin
        if (pixel_q.size() > 0 && $urandom_range(99) >= tx_idle) begin
          pix_pair_t p;
          p = pixel_q.pop_front();
          push <= 1'b1;
          pixel_a <= p.a;
          pixel_b <= p.b;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (distance_q.size() == 0) begin
          $display("%0t: unexpected transaction, distance %0h", $time, distance);
          errors++;
        end else begin
          logic [SUM_W-1:0] exp_d;
          exp_d = distance_q.pop_front();
          if (distance !== exp_d) begin
            $display("%0t: distance expected %0h actual %0h", $time, exp_d, distance);
            errors++;
          end
        end
      end
      pop <= ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic reg_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_WIDTH) width_reg = data[7:0];
    else height_reg = data[12:0];
    col_pos = 0;
    row_pos = 0;
    dist_sum = 0;
  endtask

  // queued jobs of a partial frame may still be in the back end
  task automatic drain();
    while (pixel_q.size() > 0 || push || distance_q.size() > 0) @(posedge clk);
    repeat (1000) @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd255;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic run_frame(logic [31:0] w, logic [31:0] h, int count);
    pix_pair_t p;
    reg_write(ADDR_WIDTH, w);
    reg_write(ADDR_HEIGHT, h);
    for (int i = 0; i < count; i++) begin
      p.a = rand_pixel();
      p.b = rand_pixel();
      pixel_q.push_back(p);
    end
    drain();
  endtask

  initial begin : stim
    pix_pair_t p;
    int sent;
    int w, h, n;
    sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: 3x3 frame with field extremes
    reg_write(ADDR_WIDTH, 3);
    reg_write(ADDR_HEIGHT, 3);
    p = '{8'd0, 8'd255};   pixel_q.push_back(p);
    p = '{8'd255, 8'd0};   pixel_q.push_back(p);
    p = '{8'd0, 8'd0};     pixel_q.push_back(p);
    p = '{8'd255, 8'd255}; pixel_q.push_back(p);
    p = '{8'd0, 8'd255};   pixel_q.push_back(p);
    p = '{8'd128, 8'd127}; pixel_q.push_back(p);
    p = '{8'd255, 8'd0};   pixel_q.push_back(p);
    p = '{8'd1, 8'd254};   pixel_q.push_back(p);
    p = '{8'd0, 8'd255};   pixel_q.push_back(p);
    drain();
    run_frame(1, 1, 1);
    run_frame(0, 0, 1);
    run_frame(2, 2, 4);
    run_frame(4, 3, 5);   // partial frame, restarted by the next write

    while (sent < 600) begin
      if (sent > 400) begin
        tx_idle = 0;
        rx_idle = 0;
      end else if (sent > 200) begin
        tx_idle = 52;
        rx_idle = 7;
      end
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      case ($urandom_range(9))
        0: w = 0;
        1: h = 0;
        2: begin
          w = 128;
          h = 1;
        end
        default: ;
      endcase
      n = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
      if ($urandom_range(9) == 0) n = $urandom_range(0, n - 1);
      run_frame(w, h, n);
      sent += n;
    end

    run_frame(255, 2, 256);
    run_frame(0, 8191, 64);
    run_frame(127, 13'h1001, 200);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
